[src/sds_pkg.sv]
package sds_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned SUM_W  = 64;
  localparam int unsigned FRAC_W = 16;

  localparam logic [WORD_W-1:0] WORD_MAX = '1;

  typedef enum logic [0:0] {
    REG_NORMALIZE,
    REG_SELF_WEIGHT
  } cfg_reg_t;

  typedef struct packed {
    logic              func;
    logic [WORD_W-1:0] term_mass;
    logic [WORD_W-1:0] term_density;
    logic [WORD_W-1:0] kernel_weight;
    logic              last_term;
  } term_t;

  typedef struct packed {
    logic [WORD_W-1:0] new_density;
    logic              divide_fault;
  } result_t;

  // Divide request: quotient = floor((rem_init * 2^32 + low_bits) / divisor),
  // saturated to WORD_MAX when rem_init >= divisor.
  typedef struct packed {
    logic              start;
    logic [SUM_W-1:0]  rem_init;
    logic [WORD_W-1:0] low_bits;
    logic [SUM_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_DSUM,
    ST_RDIV,
    ST_RMUL,
    ST_NSUM,
    ST_FIN,
    ST_FDIV,
    ST_OUT
  } state_t;

  function automatic logic [SUM_W-1:0] sat_add64(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

endpackage

[src/sds_div.sv]
module sds_div (
  input  logic            clk,
  input  logic            rst,
  input  sds_pkg::div_req_t req,
  output sds_pkg::div_rsp_t rsp
);
  import sds_pkg::*;

  localparam int unsigned CNT_W = $clog2(WORD_W);

  logic [SUM_W-1:0]  rem;
  logic [WORD_W-1:0] shreg;
  logic [SUM_W-1:0]  divisor;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic              done;

  logic [SUM_W:0]    trial;
  logic              fits;

  always_comb begin
    trial = {rem, shreg[WORD_W-1]};
    fits  = trial >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        divisor <= req.divisor;
        if (req.rem_init >= req.divisor) begin
          // quotient would not fit the word: saturate
          shreg <= WORD_MAX;
          done  <= 1'b1;
        end else begin
          rem   <= req.rem_init;
          shreg <= req.low_bits;
          cnt   <= CNT_W'(WORD_W - 1);
          busy  <= 1'b1;
        end
      end else if (busy) begin
        // one restoring step: shift in the next dividend bit, retire one quotient bit
        rem   <= fits ? trial[SUM_W-1:0] - divisor : trial[SUM_W-1:0];
        shreg <= {shreg[WORD_W-2:0], fits};
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = shreg;

endmodule

[src/sph_density_summation.sv]
// SPH summation density with optional Shepard normalization. A self word
// (func 0) opens a particle and is weighted by self_weight; neighbour words
// add mass * kernel_weight to a saturating Q32.32 sum, and with normalize set
// also (mass / density) * kernel_weight to a second sum. The word marked
// last_term yields one result word: the density sum as Q16.16, or the ratio of
// the two sums, saturated to all ones; a zero divisor sets divide_fault. Words
// are taken one at a time and term_stall stays high while one is in work.
// In plain mode a word passes through accept, multiply and accumulate. In
// normalize mode a word also passes through the 32-step radix-2 divider
// that forms mass / density, and the last word adds a final divide through
// the same divider. Config writes are always ready and belong between
// particles.
module sph_density_summation (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     term_valid,
  output logic                     term_stall,
  input  sds_pkg::term_t           term,
  output logic                     result_valid,
  input  logic                     result_stall,
  output sds_pkg::result_t         result,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  sds_pkg::cfg_reg_t        cfg_index,
  input  logic [sds_pkg::WORD_W-1:0] cfg_data
);
  import sds_pkg::*;

  state_t state, state_next;

  logic              normalize;
  logic [WORD_W-1:0] self_weight;

  logic [WORD_W-1:0] mass;
  logic [WORD_W-1:0] dens;
  logic [WORD_W-1:0] wgt;
  logic              last;
  logic              norm_mode;
  logic [WORD_W-1:0] ratio;
  logic [SUM_W-1:0]  prod;
  logic [SUM_W-1:0]  density_sum;
  logic [SUM_W-1:0]  norm_sum;
  logic              fault_seen;
  logic [WORD_W-1:0] res_value;
  logic              res_fault;

  logic              term_take;
  logic              out_load;
  logic [WORD_W-1:0] mul_a;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  assign cfg_ready = 1'b1;
  assign term_take = term_valid && !term_stall;
  assign out_load  = (state == ST_OUT) && (!result_valid || !result_stall);
  assign mul_a     = (state == ST_RMUL) ? ratio : mass;

  sds_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    term_stall       = 1'b1;
    div_req.start    = 1'b0;
    div_req.rem_init = {{(SUM_W-FRAC_W){1'b0}}, mass[WORD_W-1:FRAC_W]};
    div_req.low_bits = {mass[FRAC_W-1:0], {(WORD_W-FRAC_W){1'b0}}};
    div_req.divisor  = {{(SUM_W-WORD_W){1'b0}}, dens};
    case (state)
      ST_IDLE: begin
        term_stall = 1'b0;
        if (term_valid) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: state_next = ST_DSUM;
      ST_DSUM: begin
        if (norm_mode) begin
          if (dens == '0) begin
            state_next = ST_RMUL;
          end else begin
            div_req.start = 1'b1;
            state_next    = ST_RDIV;
          end
        end else begin
          state_next = last ? ST_FIN : ST_IDLE;
        end
      end
      ST_RDIV: begin
        if (div_rsp.done) begin
          state_next = ST_RMUL;
        end
      end
      ST_RMUL: state_next = ST_NSUM;
      ST_NSUM: state_next = last ? ST_FIN : ST_IDLE;
      ST_FIN: begin
        div_req.rem_init = {{FRAC_W{1'b0}}, density_sum[SUM_W-1:FRAC_W]};
        div_req.low_bits = {density_sum[FRAC_W-1:0], {(WORD_W-FRAC_W){1'b0}}};
        div_req.divisor  = norm_sum;
        if (norm_mode && norm_sum != '0) begin
          div_req.start = 1'b1;
          state_next    = ST_FDIV;
        end else begin
          state_next = ST_OUT;
        end
      end
      ST_FDIV: begin
        if (div_rsp.done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!result_valid || !result_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      normalize   <= 1'b0;
      self_weight <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_NORMALIZE:   normalize   <= cfg_data[0];
        REG_SELF_WEIGHT: self_weight <= cfg_data;
        default: ;
      endcase
    end
  end

  // item registers and shared multiplier
  always_ff @(posedge clk) begin
    if (term_take) begin
      mass      <= term.term_mass;
      dens      <= term.term_density;
      wgt       <= term.func ? term.kernel_weight : self_weight;
      last      <= term.last_term;
      norm_mode <= normalize;
    end
    if (state == ST_MUL || state == ST_RMUL) begin
      prod <= SUM_W'(mul_a) * SUM_W'(wgt);
    end
    if (state == ST_DSUM && dens == '0) begin
      ratio <= WORD_MAX;
    end else if (state == ST_RDIV && div_rsp.done) begin
      ratio <= div_rsp.quotient;
    end
    if (state == ST_FIN) begin
      res_fault <= fault_seen;
      if (norm_mode) begin
        res_value <= WORD_MAX;
        if (norm_sum == '0) begin
          res_fault <= 1'b1;
        end
      end else if (density_sum[SUM_W-1:WORD_W+FRAC_W] != '0) begin
        res_value <= WORD_MAX;
      end else begin
        res_value <= density_sum[WORD_W+FRAC_W-1:FRAC_W];
      end
    end else if (state == ST_FDIV && div_rsp.done) begin
      res_value <= div_rsp.quotient;
    end
  end

  // accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      density_sum <= '0;
      norm_sum    <= '0;
      fault_seen  <= 1'b0;
    end else if ((term_take && !term.func) || out_load) begin
      density_sum <= '0;
      norm_sum    <= '0;
      fault_seen  <= 1'b0;
    end else begin
      if (state == ST_DSUM) begin
        density_sum <= sat_add64(density_sum, prod);
        if (norm_mode && dens == '0) begin
          fault_seen <= 1'b1;
        end
      end
      if (state == ST_NSUM) begin
        norm_sum <= sat_add64(norm_sum, prod);
      end
    end
  end

  // output register: hold the word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.new_density  <= res_value;
      result.divide_fault <= res_fault;
    end
  end

endmodule

[src/sds_checker.sv]
module sds_checker (
  input logic             clk,
  input logic             rst,
  input logic             term_valid,
  input logic             term_stall,
  input logic             result_valid,
  input logic             result_stall,
  input sds_pkg::result_t result
);

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result word changed or dropped while stalled");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    term_valid && !term_stall |=> term_stall)
    else $error("block ready again right after taking a word");

  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(term_stall))
    else $error("result word appeared without preceding work");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

endmodule

bind sph_density_summation sds_checker u_sds_checker (
  .clk          (clk),
  .rst          (rst),
  .term_valid   (term_valid),
  .term_stall   (term_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
